// File: design/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the scatter schedule
// Field widths, sequencer control word layout and the microprogram table.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int NODE_W   = 9;
	localparam int RANK_W   = 8;
	localparam int SIZE_W   = 32;
	localparam int OFS_W    = 33;
	localparam int KIND_W   = 2;
	localparam int DIV_W    = 33;
	localparam int ITER_W   = 6;
	localparam int SHIFT_W  = 4;
	localparam int STEP_W   = 4;
	localparam int MAX_NODES = 256;

	localparam logic [KIND_W-1:0] KIND_SCATTER   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SMALL     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLGATHER = 2'd2;

	typedef logic [STEP_W-1:0] bss_step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_MOD,
		OP_MASK_STEP,
		OP_DIV_PIECE,
		OP_CHILD_INIT,
		OP_CHILD,
		OP_ALLGATHER
	} bss_op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_REQ,
		COND_DIV_BUSY,
		COND_MASK_ZERO,
		COND_SMALL
	} bss_cond_t;

	typedef struct packed {
		bss_op_t   op;
		logic      wait_out;
		bss_cond_t cond;
		bss_step_t target;
	} bss_uword_t;

	typedef struct packed {
		logic no_req;
		logic div_busy;
		logic mask_zero;
		logic small_mode;
		logic out_blocked;
	} bss_stat_t;

	typedef struct packed {
		bss_op_t op;
		logic    idle;
	} bss_ctrl_t;

	localparam bss_step_t STEP_WAIT        = 4'd0;
	localparam bss_step_t STEP_MOD_START   = 4'd1;
	localparam bss_step_t STEP_MOD_WAIT    = 4'd2;
	localparam bss_step_t STEP_PIECE_START = 4'd3;
	localparam bss_step_t STEP_PIECE_WAIT  = 4'd4;
	localparam bss_step_t STEP_CHILD_INIT  = 4'd5;
	localparam bss_step_t STEP_CHECK       = 4'd6;
	localparam bss_step_t STEP_CHILD       = 4'd7;
	localparam bss_step_t STEP_TAIL        = 4'd8;
	localparam bss_step_t STEP_ALLGATHER   = 4'd9;

	// microprogram: one control word per step
	function automatic bss_uword_t bss_rom(input bss_step_t addr);
		bss_uword_t w;
		w = '{op: OP_NONE, wait_out: 1'b0, cond: COND_NEVER, target: STEP_WAIT};
		case (addr)
			STEP_WAIT:        w = '{OP_LOAD,       1'b0, COND_NO_REQ,    STEP_WAIT};
			STEP_MOD_START:   w = '{OP_DIV_MOD,    1'b0, COND_NEVER,     STEP_WAIT};
			STEP_MOD_WAIT:    w = '{OP_MASK_STEP,  1'b0, COND_DIV_BUSY,  STEP_MOD_WAIT};
			STEP_PIECE_START: w = '{OP_DIV_PIECE,  1'b0, COND_NEVER,     STEP_WAIT};
			STEP_PIECE_WAIT:  w = '{OP_MASK_STEP,  1'b0, COND_DIV_BUSY,  STEP_PIECE_WAIT};
			STEP_CHILD_INIT:  w = '{OP_CHILD_INIT, 1'b0, COND_NEVER,     STEP_WAIT};
			STEP_CHECK:       w = '{OP_NONE,       1'b0, COND_MASK_ZERO, STEP_TAIL};
			STEP_CHILD:       w = '{OP_CHILD,      1'b1, COND_ALWAYS,    STEP_CHECK};
			STEP_TAIL:        w = '{OP_NONE,       1'b0, COND_SMALL,     STEP_WAIT};
			STEP_ALLGATHER:   w = '{OP_ALLGATHER,  1'b1, COND_ALWAYS,    STEP_WAIT};
			default:          w = '{OP_NONE,       1'b0, COND_ALWAYS,    STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: design/bss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_div: restoring divider, one quotient bit per cycle
// The caller aligns the dividend high and sets the iteration count.
// ----------------------------------------------------------------------------
module bss_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bss_pkg::DIV_W-1:0]         dividend,
	input  logic [bss_pkg::NODE_W-1:0]        divisor,
	input  logic [bss_pkg::ITER_W-1:0]        iters,
	output logic                              busy,
	output logic [bss_pkg::DIV_W-1:0]         quotient,
	output logic [bss_pkg::NODE_W-1:0]        remainder
);
	import bss_pkg::*;

	logic                busy_q;
	logic [ITER_W-1:0]   cnt_q;
	logic [DIV_W-1:0]    quo_q;
	logic [NODE_W-1:0]   rem_q;
	logic [NODE_W-1:0]   dvs_q;
	logic [NODE_W:0]     trial;
	logic                fits;
	logic [NODE_W:0]     diff;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ITER_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top trial bit drops
			rem_q <= fits ? diff[NODE_W-1:0] : trial[NODE_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: design/bss_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_seq: microprogram sequencer
// Step counter, control store lookup and conditional jumps.
// ----------------------------------------------------------------------------
module bss_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  bss_pkg::bss_stat_t  stat,
	output bss_pkg::bss_ctrl_t  ctrl
);
	import bss_pkg::*;

	bss_step_t  step_q;
	bss_uword_t uw;
	logic       hold;
	logic       take;

	assign uw   = bss_rom(step_q);
	assign hold = uw.wait_out && stat.out_blocked;

	always_comb begin
		case (uw.cond)
			COND_NEVER:     take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_NO_REQ:    take = stat.no_req;
			COND_DIV_BUSY:  take = stat.div_busy;
			COND_MASK_ZERO: take = stat.mask_zero;
			COND_SMALL:     take = stat.small_mode;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (!hold) begin
			step_q <= take ? uw.target : step_q + 1'b1;
		end
	end

	// a step waiting on the output register does nothing
	assign ctrl.op   = hold ? OP_NONE : uw.op;
	assign ctrl.idle = step_q == STEP_WAIT;

endmodule

// File: design/binomial_scatter_schedule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_scatter_schedule: send list for a binomial tree scatter
// Turns one scatter request into the ordered list of sends of this node.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall) takes one scatter request;
//   the send channel (send_valid / send_stall) gives the sends it causes,
//   last_send marking the final one. A request in small mode with no child
//   gives no send at all.
//   One request is worked on at a time: req_stall is high from the transfer
//   until the sequencer returns to its wait step. Setup is a modulo pass
//   and a divide on the shared restoring divider plus three single steps;
//   then come two steps per tree level, the tail step, the allgather step
//   (skipped in small mode) and the wait step.
//   Sends wait in one output register; while send_stall is high and a send
//   waits there, the sequencer holds on the next child or allgather step.
//   The next request may be taken while the final send still waits there.
//   Reset clears the step counter, the divider and the output valid.
// ----------------------------------------------------------------------------
module binomial_scatter_schedule (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [bss_pkg::NODE_W-1:0]        node_count,
	input  logic [bss_pkg::RANK_W-1:0]        my_rank,
	input  logic [bss_pkg::SIZE_W-1:0]        total_bytes,
	input  logic [bss_pkg::SIZE_W-1:0]        received_size,
	input  logic                              small_message,
	output logic                              send_valid,
	input  logic                              send_stall,
	output logic [bss_pkg::KIND_W-1:0]        send_kind,
	output logic [bss_pkg::RANK_W-1:0]        dest_rank,
	output logic [bss_pkg::SIZE_W-1:0]        send_size,
	output logic [bss_pkg::OFS_W-1:0]         source_offset,
	output logic                              last_send
);
	import bss_pkg::*;

	localparam int OFF_W = SIZE_W + RANK_W;

	bss_ctrl_t ctrl;
	bss_stat_t stat;

	logic                req_fire;
	logic [NODE_W-1:0]   nodes_q;
	logic [RANK_W-1:0]   rank_q;
	logic [SIZE_W-1:0]   total_q;
	logic [SIZE_W-1:0]   recv_q;
	logic                small_q;
	logic [NODE_W-1:0]   mask_q;
	logic [SHIFT_W-1:0]  k_q;
	logic [SIZE_W-1:0]   piece_q;
	logic [SIZE_W-1:0]   cur_q;
	logic [RANK_W-1:0]   ag_dest_q;
	logic [NODE_W-1:0]   nodes_in;

	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [ITER_W-1:0]   div_iters;
	logic                div_busy;
	logic [DIV_W-1:0]    div_quo;
	logic [NODE_W-1:0]   div_rem;

	logic [OFF_W-1:0]    off;
	logic                cur_gt;
	logic [SIZE_W-1:0]   sz;
	logic                child_ok;
	logic                emit;
	logic                load_out;

	logic                send_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [RANK_W-1:0]   dest_q;
	logic [SIZE_W-1:0]   size_q;
	logic [OFS_W-1:0]    ofs_q;
	logic                last_q;

	bss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign req_stall = !ctrl.idle;
	assign req_fire  = req_valid && !req_stall;

	assign stat.no_req      = !req_valid;
	assign stat.div_busy    = div_busy;
	assign stat.mask_zero   = mask_q == '0;
	assign stat.small_mode  = small_q;
	assign stat.out_blocked = send_valid_q && send_stall;

	// zero nodes counts as one, too many saturates
	always_comb begin
		if (node_count == '0)
			nodes_in = NODE_W'(1);
		else if (node_count > NODE_W'(MAX_NODES))
			nodes_in = NODE_W'(MAX_NODES);
		else
			nodes_in = node_count;
	end

	// ring neighbor first (short pass), then ceil(total / nodes)
	assign div_start = (ctrl.op == OP_DIV_MOD) || (ctrl.op == OP_DIV_PIECE);
	always_comb begin
		if (ctrl.op == OP_DIV_MOD) begin
			div_dividend = {{1'b0, rank_q} + NODE_W'(1), {(DIV_W-NODE_W){1'b0}}};
			div_iters    = ITER_W'(NODE_W);
		end else begin
			div_dividend = {1'b0, total_q} + DIV_W'(nodes_q) - DIV_W'(1);
			div_iters    = ITER_W'(DIV_W);
		end
	end

	bss_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (nodes_q),
		.iters     (div_iters),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// child at rank + mask gets the tail beyond mask * piece
	assign off      = {{RANK_W{1'b0}}, piece_q} << k_q[2:0];
	assign cur_gt   = {{RANK_W{1'b0}}, cur_q} > off;
	assign sz       = cur_gt ? cur_q - off[SIZE_W-1:0] : '0;
	assign child_ok = ({2'b0, rank_q} + {1'b0, mask_q}) < {1'b0, nodes_q};
	assign emit     = child_ok && (small_q || cur_gt);
	assign load_out = (ctrl.op == OP_ALLGATHER) || ((ctrl.op == OP_CHILD) && emit);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			nodes_q <= nodes_in;
			rank_q  <= my_rank;
			total_q <= total_bytes;
			recv_q  <= received_size;
			small_q <= small_message;
		end
		case (ctrl.op)
			OP_DIV_MOD: begin
				mask_q <= NODE_W'(1);
				k_q    <= '0;
			end
			OP_MASK_STEP: begin
				if (((mask_q & {1'b0, rank_q}) == '0) && (mask_q < nodes_q)) begin
					mask_q <= mask_q << 1;
					k_q    <= k_q + 1'b1;
				end
			end
			OP_DIV_PIECE: begin
				ag_dest_q <= div_rem[RANK_W-1:0];
			end
			OP_CHILD_INIT: begin
				piece_q <= div_quo[SIZE_W-1:0];
				cur_q   <= recv_q;
				mask_q  <= mask_q >> 1;
				k_q     <= k_q - 1'b1;
			end
			OP_CHILD: begin
				if (child_ok && !small_q)
					cur_q <= cur_q - sz;
				mask_q <= mask_q >> 1;
				k_q    <= k_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid_q <= 1'b0;
		end else if (load_out) begin
			send_valid_q <= 1'b1;
		end else if (!send_stall) begin
			send_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ctrl.op == OP_ALLGATHER) begin
				kind_q <= KIND_ALLGATHER;
				dest_q <= ag_dest_q;
				size_q <= (piece_q < recv_q) ? piece_q : recv_q;
				ofs_q  <= '0;
				last_q <= 1'b1;
			end else if (small_q) begin
				kind_q <= KIND_SMALL;
				dest_q <= rank_q + mask_q[RANK_W-1:0];
				size_q <= recv_q;
				ofs_q  <= '0;
				// the child at distance one exists whenever any child does
				last_q <= mask_q == NODE_W'(1);
			end else begin
				kind_q <= KIND_SCATTER;
				dest_q <= rank_q + mask_q[RANK_W-1:0];
				size_q <= sz;
				ofs_q  <= off[OFS_W-1:0];
				last_q <= 1'b0;
			end
		end
	end

	assign send_valid    = send_valid_q;
	assign send_kind     = kind_q;
	assign dest_rank     = dest_q;
	assign send_size     = size_q;
	assign source_offset = ofs_q;
	assign last_send     = last_q;

`ifndef SYNTHESIS
	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_CHILD) |-> $onehot(mask_q))
		else $error("tree mask is not a single bit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(send_valid_q && send_stall))
		else $error("send register overwritten while stalled");

	a_ring_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_ALLGATHER) |-> ({1'b0, ag_dest_q} < nodes_q))
		else $error("allgather destination outside the ring");

	a_small_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(send_valid_q && (kind_q == KIND_SMALL || kind_q == KIND_ALLGATHER))
			|-> (ofs_q == '0))
		else $error("nonzero offset on a whole-chunk send");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> !div_busy)
		else $error("request taken while the divider is running");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for binomial_scatter_schedule
// Sends scatter requests with random gaps and receiver back-pressure, works
// out the expected send list of every request and checks each send transfer
// field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	import bss_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 11;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [RANK_W-1:0] dest;
		logic [SIZE_W-1:0] size;
		logic [OFS_W-1:0]  offset;
		logic              last;
	} send_rec_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [NODE_W-1:0] node_count;
	logic [RANK_W-1:0] my_rank;
	logic [SIZE_W-1:0] total_bytes;
	logic [SIZE_W-1:0] received_size;
	logic              small_message;
	logic              send_valid;
	logic              send_stall;
	logic [KIND_W-1:0] send_kind;
	logic [RANK_W-1:0] dest_rank;
	logic [SIZE_W-1:0] send_size;
	logic [OFS_W-1:0]  source_offset;
	logic              last_send;

	send_rec_t   expected_sends[$];
	int          mismatches = 0;
	int          requests_sent = 0;
	int          small_requests = 0;
	int          stray_requests = 0;
	int          sends_checked = 0;
	int          long_holds = 0;
	int          quiet_cycles = 0;
	bit          gaps_on = 1'b1;
	bit          sink_noise = 1'b1;
	int unsigned hold_request = 0;

	binomial_scatter_schedule dut (.*);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [SIZE_W-1:0] rand_bytes();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 64);
			1: return $urandom_range(0, 100000);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic send_rec_t make_send(input logic [KIND_W-1:0] kind,
		input longint unsigned dest, input longint unsigned size,
		input longint unsigned offset);
		send_rec_t rec;
		rec.kind   = kind;
		rec.dest   = dest[RANK_W-1:0];
		rec.size   = size[SIZE_W-1:0];
		rec.offset = offset[OFS_W-1:0];
		rec.last   = 1'b0;
		return rec;
	endfunction

	// expected send list of one scatter request
	function automatic void predict_sends(input logic [NODE_W-1:0] nc,
		input logic [RANK_W-1:0] rk, input logic [SIZE_W-1:0] tot,
		input logic [SIZE_W-1:0] rcv, input logic sm);
		longint unsigned nodes, rank_v, tot_v, recv_v, piece, cur, m, off, sz;
		send_rec_t recs[10];
		send_rec_t rec;
		int n;
		int i;
		n = 0;
		nodes = 64'(nc);
		rank_v = 64'(rk);
		tot_v = 64'(tot);
		recv_v = 64'(rcv);
		if (nodes == 0)
			nodes = 1;
		if (nodes > MAX_NODES)
			nodes = 64'(MAX_NODES);
		piece = (tot_v + nodes - 1) / nodes;
		// lowest set bit of the rank, or the tree top for the root
		m = 1;
		while ((m & rank_v) == 0 && m < nodes)
			m = m << 1;
		cur = recv_v;
		for (m = m >> 1; m > 0; m = m >> 1) begin
			if (rank_v + m < nodes) begin
				if (sm) begin
					recs[n] = make_send(KIND_SMALL, rank_v + m, recv_v, 0);
					n++;
				end else begin
					off = m * piece;
					sz = (cur <= off) ? 0 : cur - off;
					cur = cur - sz;
					if (sz > 0) begin
						recs[n] = make_send(KIND_SCATTER, rank_v + m, sz, off);
						n++;
					end
				end
			end
		end
		if (!sm) begin
			sz = (piece < recv_v) ? piece : recv_v;
			recs[n] = make_send(KIND_ALLGATHER, (rank_v + 1) % nodes, sz, 0);
			n++;
		end
		for (i = 0; i < n; i++) begin
			rec = recs[i];
			rec.last = (i == n - 1);
			expected_sends.insert(expected_sends.size(), rec);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	// gap, then one request held until its transfer
	task automatic send_request(input logic [NODE_W-1:0] nc, input logic [RANK_W-1:0] rk,
		input logic [SIZE_W-1:0] tot, input logic [SIZE_W-1:0] rcv, input logic sm);
		int unsigned gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			req_valid     <= 1'b0;
			node_count    <= NODE_W'($urandom);
			my_rank       <= RANK_W'($urandom);
			total_bytes   <= $urandom;
			received_size <= $urandom;
			small_message <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		node_count    <= nc;
		my_rank       <= rk;
		total_bytes   <= tot;
		received_size <= rcv;
		small_message <= sm;
		req_valid     <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_sends(nc, rk, tot, rcv, sm);
		requests_sent++;
		if (sm)
			small_requests++;
		if (nc == 0 || nc > MAX_NODES || rk >= nc)
			stray_requests++;
	endtask

	task automatic test_node_count_edges();
		send_request(0, 0, 100, 100, 1'b0);
		send_request(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_request(1, 0, 500, 500, 1'b1);
		send_request(257, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_request(511, 3, 32'h8000_0001, 32'h4000_0000, 1'b0);
		send_request(256, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_request(256, 255, 1000, 3, 1'b0);
	endtask

	task automatic test_rank_edges();
		send_request(5, 200, 1000, 1000, 1'b0);
		send_request(5, 200, 1000, 1000, 1'b1);
		send_request(3, 1, 999, 333, 1'b0);
		send_request(7, 4, 7000, 3000, 1'b0);
		send_request(256, 128, 25600, 12800, 1'b0);
		send_request(2, 0, 9, 9, 1'b0);
	endtask

	task automatic test_size_edges();
		send_request(8, 0, 0, 0, 1'b0);
		send_request(8, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// received chunk smaller than one piece
		send_request(8, 0, 1000, 10, 1'b0);
		send_request(16, 0, 15, 15, 1'b0);
		send_request(100, 0, 32'hFFFF_FFFF, 5000, 1'b0);
	endtask

	task automatic test_small_mode();
		send_request(256, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(13, 4, 1300, 400, 1'b1);
		send_request(6, 2, 0, 0, 1'b1);
		send_request(9, 0, 77, 77, 1'b1);
	endtask

	// receiver holds off while deep requests keep coming
	task automatic test_output_backpressure();
		int i;
		gaps_on = 1'b0;
		hold_request = HOLD_CYCLES;
		for (i = 0; i < 20; i++)
			send_request(NODE_W'(MAX_NODES), '0, rand_bytes(), rand_bytes(), i[0] & i[1]);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_schedules(input int count);
		logic [NODE_W-1:0] nc;
		logic [RANK_W-1:0] rk;
		logic [SIZE_W-1:0] tot;
		logic [SIZE_W-1:0] rcv;
		logic              sm;
		longint unsigned   tot_v, piece, low_bit, start, share;
		int                i;
		for (i = 0; i < count; i++) begin
			// a stretch with no idling on either side
			if (i == count / 3) begin
				gaps_on = 1'b0;
				sink_noise = 1'b0;
			end
			if (i == count / 3 + 60) begin
				gaps_on = 1'b1;
				sink_noise = 1'b1;
			end
			tot = rand_bytes();
			tot_v = 64'(tot);
			sm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85) begin
				case ($urandom_range(0, 3))
					0: nc = NODE_W'($urandom_range(1, 16));
					1: nc = NODE_W'(1) << $urandom_range(0, 8);
					2: nc = NODE_W'(MAX_NODES);
					default: nc = NODE_W'($urandom_range(1, MAX_NODES));
				endcase
				rk = ($urandom_range(0, 3) == 0) ? '0 : RANK_W'($urandom_range(0, nc - 1));
				if ($urandom_range(0, 2) == 0) begin
					rcv = rand_bytes();
				end else if (rk == 0) begin
					rcv = tot;
				end else begin
					// chunk this rank gets from its parent
					piece = (tot_v + nc - 1) / nc;
					low_bit = 1;
					while ((low_bit & rk) == 0)
						low_bit = low_bit << 1;
					start = rk * piece;
					share = low_bit * piece;
					if (start >= tot_v)
						rcv = '0;
					else if (tot_v - start < share)
						rcv = SIZE_W'(tot_v - start);
					else
						rcv = SIZE_W'(share);
				end
			end else begin
				nc = NODE_W'($urandom_range(0, 511));
				rk = RANK_W'($urandom_range(0, 255));
				rcv = rand_bytes();
			end
			send_request(nc, rk, tot, rcv, sm);
		end
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	initial begin : sink_proc
		int unsigned len;
		send_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				len = hold_request;
				hold_request = 0;
				long_holds++;
			end else if (sink_noise && $urandom_range(0, 3) == 0) begin
				len = pick_gap();
			end else begin
				len = 0;
			end
			if (len != 0) begin
				send_stall <= 1'b1;
				repeat (len) @(posedge clk);
				send_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : send_check
		send_rec_t want;
		if (arst_n && send_valid && !send_stall) begin
			if (expected_sends.size() == 0) begin
				report_mismatch("send with nothing expected, dest_rank", dest_rank, 0);
			end else begin
				want = expected_sends[0];
				expected_sends.delete(0);
				sends_checked++;
				if (send_kind !== want.kind)
					report_mismatch("send_kind", send_kind, want.kind);
				if (dest_rank !== want.dest)
					report_mismatch("dest_rank", dest_rank, want.dest);
				if (send_size !== want.size)
					report_mismatch("send_size", send_size, want.size);
				if (source_offset !== want.offset)
					report_mismatch("source_offset", source_offset, want.offset);
				if (last_send !== want.last)
					report_mismatch("last_send", last_send, want.last);
			end
		end
	end

	// ends the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (send_valid && !send_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : main
		arst_n        <= 1'b0;
		req_valid     <= 1'b0;
		node_count    <= '0;
		my_rank       <= '0;
		total_bytes   <= '0;
		received_size <= '0;
		small_message <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_node_count_edges();
		test_rank_edges();
		test_size_edges();
		test_small_mode();
		test_output_backpressure();
		test_random_schedules(380);

		req_valid <= 1'b0;
		while (expected_sends.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d small mode, %0d with node count or rank out of range",
			requests_sent, small_requests, stray_requests);
		$display("checked %0d sends across %0d long receiver hold-offs",
			sends_checked, long_holds);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
